/* rtl/core/pfra_pkg.sv */
package pfra_pkg;

  localparam int ADDR_W = 25;
  localparam int CNT_W  = 8;

  // Physical base of the counted region and the count that marks a page used
  localparam logic [ADDR_W-1:0] BASE_ADDR  = 25'h010_0000;
  localparam logic [12:0]       BASE_PAGE  = BASE_ADDR[24:12];
  localparam logic [CNT_W-1:0]  USED_COUNT = 8'd100;
  localparam logic [CNT_W-1:0]  MAX_COUNT  = 8'd255;

  localparam logic [2:0] CMD_ALLOC   = 3'd0;
  localparam logic [2:0] CMD_FREE    = 3'd1;
  localparam logic [2:0] CMD_ADD_REF = 3'd2;
  localparam logic [2:0] CMD_QUERY   = 3'd3;
  localparam logic [2:0] CMD_INIT    = 3'd4;

  localparam logic [2:0] STS_OK           = 3'd0;
  localparam logic [2:0] STS_OOM          = 3'd1;
  localparam logic [2:0] STS_NONEXIST     = 3'd2;
  localparam logic [2:0] STS_ALREADY_FREE = 3'd3;
  localparam logic [2:0] STS_IGNORED_LOW  = 3'd4;
  localparam logic [2:0] STS_SATURATED    = 3'd5;

  localparam logic REG_USABLE_START = 1'b0;
  localparam logic REG_MEMORY_END   = 1'b1;

  typedef struct packed {
    logic [2:0]        command;
    logic [ADDR_W-1:0] page_addr;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_addr;
    logic [CNT_W-1:0]  ref_count;
    logic [2:0]        status;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] usable_start;
    logic [ADDR_W-1:0] memory_end;
  } cfg_t;

endpackage

/* rtl/core/pfra_ram.sv */
module pfra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/core/pfra_ctrl.sv */
module pfra_ctrl #(
  parameter int NUM_PAGES = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  pfra_pkg::req_t               request,
  input  pfra_pkg::cfg_t               cfg,
  output logic                         busy,
  output logic                         done,
  output pfra_pkg::rsp_t               result,
  output logic [$clog2(NUM_PAGES)-1:0] ram_rd_addr,
  input  logic [pfra_pkg::CNT_W-1:0]   ram_rd_data,
  output logic                         ram_wr_en,
  output logic [$clog2(NUM_PAGES)-1:0] ram_wr_addr,
  output logic [pfra_pkg::CNT_W-1:0]   ram_wr_data
);

  localparam int IDX_W = $clog2(NUM_PAGES);
  localparam int CW    = (IDX_W + 1 > 13) ? IDX_W + 1 : 13;
  localparam int SW    = (IDX_W + 2 > 16) ? IDX_W + 2 : 16;

  localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(NUM_PAGES - 1);
  localparam logic [IDX_W:0]       NP_U     = (IDX_W + 1)'(NUM_PAGES);
  localparam logic [CW-1:0]        NP_C     = CW'(NUM_PAGES);
  localparam logic signed [SW-1:0] NP_S     = SW'(NUM_PAGES);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SWEEP  = 3'd1;
  localparam logic [2:0] S_PREP_A = 3'd2;
  localparam logic [2:0] S_PREP_B = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_RD     = 3'd5;
  localparam logic [2:0] S_EXEC   = 3'd6;

  logic [2:0]              state;
  logic [2:0]              cmd_q;
  logic [IDX_W-1:0]        pidx_q;
  logic [IDX_W-1:0]        sweep_idx;
  logic                    report;
  logic [IDX_W:0]          lo;
  logic [IDX_W:0]          hi;
  logic signed [SW-1:0]    first_q;
  logic [12:0]             n_q;
  logic [IDX_W-1:0]        scan_idx;
  logic                    pend_v;
  logic                    pend_last;
  logic [IDX_W-1:0]        pend_idx;

  logic [12:0]             pidx13;
  logic [CW-1:0]           pidx_ext;
  logic                    is_low;
  logic                    beyond;
  logic                    above_end;
  logic signed [25:0]      us_diff;
  logic signed [25:0]      first_full;
  logic [24:0]             me_diff;
  logic [12:0]             n_val;
  logic signed [SW-1:0]    end_s;
  logic [IDX_W:0]          lo_c;
  logic [IDX_W:0]          hi_c;
  logic                    in_range;
  logic                    found;

  // Address decode for the single-page commands
  assign pidx13    = request.page_addr[24:12] - pfra_pkg::BASE_PAGE;
  assign pidx_ext  = CW'(pidx13);
  assign is_low    = request.page_addr < pfra_pkg::BASE_ADDR;
  assign beyond    = pidx_ext >= NP_C;
  assign above_end = request.page_addr >= cfg.memory_end;

  // Init window: first page is floor((start - base) / 4 KiB), may be negative
  assign us_diff    = $signed({1'b0, cfg.usable_start}) - $signed({1'b0, pfra_pkg::BASE_ADDR});
  assign first_full = us_diff >>> 12;
  assign me_diff    = cfg.memory_end - cfg.usable_start;
  assign n_val      = (cfg.memory_end > cfg.usable_start) ? me_diff[24:12] : 13'd0;
  assign end_s      = first_q + $signed(SW'({1'b0, n_q}));

  always_comb begin
    if (first_q < 0) begin
      lo_c = '0;
    end else if (first_q >= NP_S) begin
      lo_c = NP_U;
    end else begin
      lo_c = first_q[IDX_W:0];
    end
    if (end_s <= 0) begin
      hi_c = '0;
    end else if (end_s >= NP_S) begin
      hi_c = NP_U;
    end else begin
      hi_c = end_s[IDX_W:0];
    end
  end

  assign in_range = ({1'b0, sweep_idx} >= lo) && ({1'b0, sweep_idx} < hi);
  assign found    = pend_v && (ram_rd_data == '0);
  assign busy     = state != S_IDLE;

  // Single memory port pair: reads from the scan or the addressed page
  always_comb begin
    ram_rd_addr = (state == S_RD) ? pidx_q : scan_idx;
    ram_wr_en   = 1'b0;
    ram_wr_addr = sweep_idx;
    ram_wr_data = in_range ? '0 : pfra_pkg::USED_COUNT;
    unique case (state)
      S_SWEEP: begin
        ram_wr_en = 1'b1;
      end
      S_SCAN: begin
        ram_wr_en   = found;
        ram_wr_addr = pend_idx;
        ram_wr_data = pfra_pkg::CNT_W'(1);
      end
      S_EXEC: begin
        ram_wr_addr = pidx_q;
        if (cmd_q == pfra_pkg::CMD_FREE) begin
          ram_wr_en   = ram_rd_data != '0;
          ram_wr_data = ram_rd_data - pfra_pkg::CNT_W'(1);
        end else begin
          ram_wr_en   = (cmd_q == pfra_pkg::CMD_ADD_REF) &&
                        (ram_rd_data != pfra_pkg::MAX_COUNT);
          ram_wr_data = ram_rd_data + pfra_pkg::CNT_W'(1);
        end
      end
      default: begin
        ram_wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      sweep_idx <= '0;
      lo        <= '0;
      hi        <= '0;
      report    <= 1'b0;
      done      <= 1'b0;
      pend_v    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q <= request.command;
            result <= '0;
            case (request.command) inside
              pfra_pkg::CMD_ALLOC: begin
                scan_idx <= LAST_IDX;
                pend_v   <= 1'b0;
                state    <= S_SCAN;
              end
              pfra_pkg::CMD_FREE, pfra_pkg::CMD_ADD_REF, pfra_pkg::CMD_QUERY: begin
                pidx_q <= pidx_ext[IDX_W-1:0];
                if (is_low) begin
                  done          <= 1'b1;
                  result.status <= pfra_pkg::STS_IGNORED_LOW;
                end else if (beyond ||
                             ((request.command == pfra_pkg::CMD_FREE) && above_end)) begin
                  done          <= 1'b1;
                  result.status <= pfra_pkg::STS_NONEXIST;
                end else begin
                  state <= S_RD;
                end
              end
              pfra_pkg::CMD_INIT: begin
                state <= S_PREP_A;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_PREP_A: begin
          first_q <= SW'(first_full);
          n_q     <= n_val;
          state   <= S_PREP_B;
        end
        S_PREP_B: begin
          lo        <= lo_c;
          hi        <= hi_c;
          sweep_idx <= '0;
          report    <= 1'b1;
          state     <= S_SWEEP;
        end
        S_SWEEP: begin
          sweep_idx <= sweep_idx + IDX_W'(1);
          if (sweep_idx == LAST_IDX) begin
            state  <= S_IDLE;
            report <= 1'b0;
            if (report) begin
              done   <= 1'b1;
              result <= '0;
            end
          end
        end
        S_SCAN: begin
          if (found) begin
            done               <= 1'b1;
            result.result_addr <= pfra_pkg::BASE_ADDR + (pfra_pkg::ADDR_W'(pend_idx) << 12);
            result.ref_count   <= pfra_pkg::CNT_W'(1);
            result.status      <= pfra_pkg::STS_OK;
            pend_v             <= 1'b0;
            state              <= S_IDLE;
          end else if (pend_v && pend_last) begin
            done          <= 1'b1;
            result.status <= pfra_pkg::STS_OOM;
            pend_v        <= 1'b0;
            state         <= S_IDLE;
          end else begin
            // read issued this cycle is judged next cycle
            pend_v    <= 1'b1;
            pend_idx  <= scan_idx;
            pend_last <= scan_idx == '0;
            scan_idx  <= scan_idx - IDX_W'(1);
          end
        end
        S_RD: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          done  <= 1'b1;
          state <= S_IDLE;
          case (cmd_q) inside
            pfra_pkg::CMD_FREE: begin
              if (ram_rd_data == '0) begin
                result.status <= pfra_pkg::STS_ALREADY_FREE;
              end else begin
                result.ref_count <= ram_rd_data - pfra_pkg::CNT_W'(1);
              end
            end
            pfra_pkg::CMD_ADD_REF: begin
              if (ram_rd_data == pfra_pkg::MAX_COUNT) begin
                result.ref_count <= pfra_pkg::MAX_COUNT;
                result.status    <= pfra_pkg::STS_SATURATED;
              end else begin
                result.ref_count <= ram_rd_data + pfra_pkg::CNT_W'(1);
              end
            end
            default: begin
              result.ref_count <= ram_rd_data;
            end
          endcase
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/page_frame_refcount_allocator_unit.sv */
// Reference-counted page frame allocator. One 8-bit count is held per 4 KiB
// page from 0x100000 upwards, NUM_PAGES pages, in a single-port-pair RAM.
// A command beat is taken when start is high and busy is low; its one result
// beat appears on result for exactly one cycle with done high and must be
// taken then, as nothing holds it. Results wait on the RAM's registered
// read and the one-entry-per-cycle sweep: a free, add_ref or query that is
// rejected on its address returns in the cycle after acceptance, otherwise
// it passes a read state and an execute state; alloc walks the table from
// the top one entry a cycle and returns at the first free entry, or with
// out of memory once the bottom entry is judged; init passes two prep
// states and a sweep, rewriting every entry once; an unknown command returns
// in the cycle after acceptance. After reset a sweep sets every count to
// 100, with busy high; register writes are taken throughout. Write
// usable_start and memory_end only while busy is low and no result is due.
module page_frame_refcount_allocator_unit #(
  parameter int NUM_PAGES = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  pfra_pkg::req_t               request,
  output logic                         busy,
  output logic                         done,
  output pfra_pkg::rsp_t               result,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_index,
  input  logic [pfra_pkg::ADDR_W-1:0]  cfg_data
);

  localparam int IDX_W = $clog2(NUM_PAGES);

  pfra_pkg::cfg_t           cfg;
  logic [IDX_W-1:0]         ram_rd_addr;
  logic [pfra_pkg::CNT_W-1:0] ram_rd_data;
  logic                     ram_wr_en;
  logic [IDX_W-1:0]         ram_wr_addr;
  logic [pfra_pkg::CNT_W-1:0] ram_wr_data;

  // Hold the two registers; a write lands at once, with no handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.usable_start <= pfra_pkg::BASE_ADDR;
      cfg.memory_end   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pfra_pkg::REG_USABLE_START: cfg.usable_start <= cfg_data;
        pfra_pkg::REG_MEMORY_END:   cfg.memory_end   <= cfg_data;
        default:                    cfg.memory_end   <= cfg.memory_end;
      endcase
    end
  end

  // Sequencer: decode, table scan, read-modify-write and sweep
  pfra_ctrl #(
    .NUM_PAGES (NUM_PAGES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .request     (request),
    .cfg         (cfg),
    .busy        (busy),
    .done        (done),
    .result      (result),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data)
  );

  // Count table
  pfra_ram #(
    .WIDTH (pfra_pkg::CNT_W),
    .DEPTH (NUM_PAGES)
  ) u_counts (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

`ifndef ASSERT_OFF
  // Every accepted command either starts work or returns its beat next cycle
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("accepted command neither busy nor done");

  // Table writes stay inside the table
  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_wr_en |-> ({1'b0, ram_wr_addr} < (IDX_W + 1)'(NUM_PAGES)))
    else $error("count table write out of range");

  // A failed command never returns an address
  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    done && (result.status != pfra_pkg::STS_OK) |-> result.result_addr == '0)
    else $error("address returned with error status");
`endif

endmodule

/* sim/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NUM_PAGES  = 4096;
  localparam int          IDX_W      = $clog2(NUM_PAGES);
  localparam int          ADDR_W     = pfra_pkg::ADDR_W;
  localparam int          REQ_W      = $bits(pfra_pkg::req_t);
  localparam int          PAGE_SHIFT = 12;
  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned BASE_INT   = 32'(pfra_pkg::BASE_ADDR);
  localparam logic [ADDR_W-1:0] ADDR_LIMIT = '1;
  // Last address below the counted region
  localparam logic [ADDR_W-1:0] BELOW_BASE = pfra_pkg::BASE_ADDR - 1'b1;
  // First address past the counted table; anything from here up has no count
  localparam int unsigned TABLE_END  = BASE_INT + (NUM_PAGES << PAGE_SHIFT);

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  pfra_pkg::req_t    request = '0;
  logic              busy;
  logic              done;
  pfra_pkg::rsp_t    result;
  logic              cfg_wr_en = 1'b0;
  logic              cfg_index = pfra_pkg::REG_USABLE_START;
  logic [ADDR_W-1:0] cfg_data = '0;

  // Command beats waiting to be offered, and outcomes owed by the block
  pfra_pkg::req_t cmd_feed[$];
  pfra_pkg::rsp_t pending_outcomes[$];

  // Mirror of the block's count table and address window registers
  logic [pfra_pkg::CNT_W-1:0] page_count [NUM_PAGES];
  logic [ADDR_W-1:0]          win_start;
  logic [ADDR_W-1:0]          win_end;

  logic took   = 1'b0;  // a command beat was taken at the last rising edge
  logic steady = 1'b0;  // when set, offer beats back to back with no idling
  int   faults = 0;
  int   cmd_seen [8];
  int   unknown_seen = 0;
  int   status_seen [8];

  page_frame_refcount_allocator_unit #(
    .NUM_PAGES(NUM_PAGES)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out what one command does to the mirrored table and what the block
  // must return for it. Commands are taken strictly one at a time, so the
  // table is advanced in the order of acceptance.
  function automatic pfra_pkg::rsp_t allocator_outcome(pfra_pkg::req_t rq);
    pfra_pkg::rsp_t   rs;
    int unsigned      addr;
    int unsigned      idx;
    logic [IDX_W-1:0] slot;
    int               k;
    int               first;
    int               span;
    rs   = '0;
    addr = 32'(rq.page_addr);
    idx  = (addr - BASE_INT) >> PAGE_SHIFT;
    slot = IDX_W'(idx);
    case (rq.command)
      pfra_pkg::CMD_ALLOC: begin
        // Walk down from the top page to the first free one
        rs.status = pfra_pkg::STS_OOM;
        k = NUM_PAGES - 1;
        while (k >= 0 && page_count[IDX_W'(k)] != 8'd0) k--;
        if (k >= 0) begin
          page_count[IDX_W'(k)] = 8'd1;
          rs.result_addr = ADDR_W'(BASE_INT + (k << PAGE_SHIFT));
          rs.ref_count   = 8'd1;
          rs.status      = pfra_pkg::STS_OK;
        end
      end
      pfra_pkg::CMD_FREE: begin
        // The memory end bound is checked before the table bound
        if (addr < BASE_INT) rs.status = pfra_pkg::STS_IGNORED_LOW;
        else if (addr >= win_end || idx >= NUM_PAGES) rs.status = pfra_pkg::STS_NONEXIST;
        else if (page_count[slot] == 8'd0) rs.status = pfra_pkg::STS_ALREADY_FREE;
        else begin
          page_count[slot] = page_count[slot] - 8'd1;
          rs.ref_count     = page_count[slot];
        end
      end
      pfra_pkg::CMD_ADD_REF: begin
        if (addr < BASE_INT) rs.status = pfra_pkg::STS_IGNORED_LOW;
        else if (idx >= NUM_PAGES) rs.status = pfra_pkg::STS_NONEXIST;
        else if (page_count[slot] == pfra_pkg::MAX_COUNT) begin
          rs.ref_count = pfra_pkg::MAX_COUNT;
          rs.status    = pfra_pkg::STS_SATURATED;
        end else begin
          page_count[slot] = page_count[slot] + 8'd1;
          rs.ref_count     = page_count[slot];
        end
      end
      pfra_pkg::CMD_QUERY: begin
        if (addr < BASE_INT) rs.status = pfra_pkg::STS_IGNORED_LOW;
        else if (idx >= NUM_PAGES) rs.status = pfra_pkg::STS_NONEXIST;
        else rs.ref_count = page_count[slot];
      end
      pfra_pkg::CMD_INIT: begin
        // Mark everything used, then clear the window; a start below the
        // base rounds the first page down into negative indexes
        foreach (page_count[i]) page_count[i] = pfra_pkg::USED_COUNT;
        if (win_end > win_start) begin
          span = int'((win_end - win_start) >> PAGE_SHIFT);
          if (win_start >= pfra_pkg::BASE_ADDR)
            first = int'((win_start - pfra_pkg::BASE_ADDR) >> PAGE_SHIFT);
          else first = -int'((BASE_INT - win_start + PAGE_BYTES - 1) >> PAGE_SHIFT);
          for (k = first; k < first + span; k++)
            if (k >= 0 && k < NUM_PAGES) page_count[IDX_W'(k)] = 8'd0;
        end
      end
      default: ;
    endcase
    return rs;
  endfunction

  function automatic logic [ADDR_W-1:0] page_at(int k, int unsigned offset);
    return ADDR_W'(BASE_INT + (k << PAGE_SHIFT) + offset);
  endfunction

  // Mostly land on the pages in play, with a share elsewhere in the table,
  // below the base, past the table and anywhere at all
  function automatic logic [ADDR_W-1:0] pick_addr(int lo, int hi);
    int unsigned s;
    s = $urandom_range(99);
    if (s < 72) return page_at($urandom_range(hi, lo), $urandom_range(PAGE_BYTES - 1));
    if (s < 82) return page_at($urandom_range(NUM_PAGES - 1), $urandom_range(PAGE_BYTES - 1));
    if (s < 89) return ADDR_W'($urandom_range(BASE_INT - 1));
    if (s < 95) return ADDR_W'($urandom_range(ADDR_LIMIT, TABLE_END));
    return ADDR_W'($urandom);
  endfunction

  function automatic pfra_pkg::req_t rand_req(int lo, int hi, int alloc_pct);
    pfra_pkg::req_t rq;
    int unsigned    r;
    r            = $urandom_range(99);
    rq.page_addr = pick_addr(lo, hi);
    if (r < alloc_pct) rq.command = pfra_pkg::CMD_ALLOC;
    else if (r < alloc_pct + 28) rq.command = pfra_pkg::CMD_FREE;
    else if (r < alloc_pct + 50) rq.command = pfra_pkg::CMD_ADD_REF;
    else if (r < 97) rq.command = pfra_pkg::CMD_QUERY;
    else if (r < 99) rq.command = 3'($urandom_range(7, pfra_pkg::CMD_INIT + 1));
    else rq.command = pfra_pkg::CMD_INIT;
    return rq;
  endfunction

  task automatic queue_cmd(logic [2:0] c, logic [ADDR_W-1:0] a);
    pfra_pkg::req_t rq;
    rq.command   = c;
    rq.page_addr = a;
    cmd_feed.push_back(rq);
  endtask

  // Hold until every queued beat is taken and every owed result is back.
  // Feed and start only move at the falling edge, the outcome queue and busy
  // only at the rising edge, so each is looked at on the other edge.
  task automatic settle();
    do @(posedge clk); while (cmd_feed.size() != 0 || start);
    do @(negedge clk); while (pending_outcomes.size() != 0 || busy);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_window(logic [ADDR_W-1:0] us, logic [ADDR_W-1:0] me);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= pfra_pkg::REG_USABLE_START;
    cfg_data  <= us;
    @(negedge clk);
    cfg_index <= pfra_pkg::REG_MEMORY_END;
    cfg_data  <= me;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cfg_data  <= ADDR_W'($urandom);
  endtask

  // One phase: drain, move the window, rebuild the table with init, then a
  // random mix aimed at the pages between lo and hi
  task automatic run_phase(logic [ADDR_W-1:0] us, logic [ADDR_W-1:0] me,
                           int lo, int hi, int alloc_pct, int count);
    settle();
    set_window(us, me);
    queue_cmd(pfra_pkg::CMD_INIT, ADDR_W'($urandom));
    repeat (count) cmd_feed.push_back(rand_req(lo, hi, alloc_pct));
  endtask

  // Driver: offer the next command beat at the falling edge once the current
  // one has gone, idling at random unless a steady stretch is on. Junk sits
  // on request while start is low.
  always @(negedge clk) begin
    if (rst) begin
      start   <= 1'b0;
      request <= '0;
    end else if (!start || took) begin
      if (cmd_feed.size() != 0 && (steady || $urandom_range(99) >= 37)) begin
        start   <= 1'b1;
        request <= cmd_feed.pop_front();
      end else begin
        start   <= 1'b0;
        request <= pfra_pkg::req_t'(REQ_W'($urandom));
      end
    end
  end

  // Monitor: check a result beat against the oldest owed outcome, mirror
  // register writes, then predict for a command beat taken at this edge.
  // The check comes first so a new prediction never meets its own result.
  always @(posedge clk) begin
    pfra_pkg::rsp_t want;
    if (rst) begin
      took <= 1'b0;
    end else begin
      took <= start && !busy;
      if (done) begin
        if (pending_outcomes.size() == 0) begin
          $error("result beat with nothing owed: result_addr %h ref_count %0d status %0d",
                 result.result_addr, result.ref_count, result.status);
          faults++;
        end else begin
          want = pending_outcomes.pop_front();
          if (result.result_addr !== want.result_addr) begin
            $error("result_addr mismatch: expected %h, got %h",
                   want.result_addr, result.result_addr);
            faults++;
          end
          if (result.ref_count !== want.ref_count) begin
            $error("ref_count mismatch: expected %0d, got %0d",
                   want.ref_count, result.ref_count);
            faults++;
          end
          if (result.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, result.status);
            faults++;
          end
          status_seen[want.status]++;
        end
      end
      if (cfg_wr_en) begin
        if (cfg_index == pfra_pkg::REG_MEMORY_END) win_end = cfg_data;
        else win_start = cfg_data;
      end
      if (start && !busy) begin
        if (request.command > pfra_pkg::CMD_INIT) unknown_seen++;
        else cmd_seen[request.command]++;
        pending_outcomes.push_back(allocator_outcome(request));
      end
    end
  end

  initial begin
    foreach (page_count[i]) page_count[i] = pfra_pkg::USED_COUNT;
    win_start = pfra_pkg::BASE_ADDR;
    win_end   = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Reset window: every page used and no memory end, so alloc runs dry
    // and any free lands past the end
    queue_cmd(pfra_pkg::CMD_QUERY, pfra_pkg::BASE_ADDR);
    queue_cmd(pfra_pkg::CMD_ALLOC, ADDR_LIMIT);
    queue_cmd(pfra_pkg::CMD_FREE, page_at(1, 0));
    settle();

    // Top eight pages free, memory end at the very top of the address space
    set_window(page_at(NUM_PAGES - 8, 0), ADDR_LIMIT);
    queue_cmd(pfra_pkg::CMD_INIT, '0);
    queue_cmd(pfra_pkg::CMD_QUERY, '0);
    queue_cmd(pfra_pkg::CMD_QUERY, BELOW_BASE);
    queue_cmd(pfra_pkg::CMD_QUERY, ADDR_LIMIT);
    queue_cmd(pfra_pkg::CMD_QUERY, page_at(NUM_PAGES - 1, PAGE_BYTES - 1));
    queue_cmd(pfra_pkg::CMD_FREE, page_at(NUM_PAGES - 1, 0));
    queue_cmd(pfra_pkg::CMD_ALLOC, '0);
    queue_cmd(pfra_pkg::CMD_ADD_REF, page_at(NUM_PAGES - 1, 12'h5A5));
    queue_cmd(pfra_pkg::CMD_FREE, page_at(NUM_PAGES - 1, PAGE_BYTES - 1));
    queue_cmd(pfra_pkg::CMD_FREE, page_at(NUM_PAGES - 1, 0));
    queue_cmd(pfra_pkg::CMD_FREE, ADDR_LIMIT);
    queue_cmd(pfra_pkg::CMD_FREE, ADDR_W'(TABLE_END));
    queue_cmd(pfra_pkg::CMD_ADD_REF, '0);
    queue_cmd(pfra_pkg::CMD_ADD_REF, ADDR_LIMIT);
    queue_cmd(pfra_pkg::CMD_FREE, BELOW_BASE);
    queue_cmd(pfra_pkg::CMD_FREE, pfra_pkg::BASE_ADDR);
    queue_cmd(pfra_pkg::CMD_INIT + 3'd1, ADDR_LIMIT);
    queue_cmd(pfra_pkg::CMD_INIT + 3'd2, '0);
    queue_cmd(pfra_pkg::CMD_INIT + 3'd3, ADDR_W'($urandom));
    queue_cmd(pfra_pkg::CMD_ALLOC, ADDR_LIMIT);

    // Drive page zero from 99 up into saturation, then step it back down
    repeat (160) queue_cmd(pfra_pkg::CMD_ADD_REF, page_at(0, $urandom_range(PAGE_BYTES - 1)));
    queue_cmd(pfra_pkg::CMD_FREE, page_at(0, 0));

    // Random phases; windows near the top keep alloc scans short, the
    // others are kept light on alloc since each one sweeps most of the table
    run_phase(page_at(NUM_PAGES - 64, 12'h123), ADDR_LIMIT,
              NUM_PAGES - 72, NUM_PAGES - 1, 10, 450);
    run_phase('0, '0, NUM_PAGES - 96, NUM_PAGES - 1, 3, 60);
    run_phase(ADDR_W'(BASE_INT - 2048), page_at(256, 0), 0, 300, 2, 150);
    run_phase(ADDR_LIMIT, ADDR_LIMIT, NUM_PAGES - 16, NUM_PAGES - 1, 2, 50);
    run_phase(page_at(NUM_PAGES - 96, 0), page_at(NUM_PAGES - 6, 12'hABC),
              NUM_PAGES - 106, NUM_PAGES - 1, 12, 700);
    settle();
    steady = 1'b1;
    run_phase(page_at(NUM_PAGES - 32, 0), ADDR_LIMIT,
              NUM_PAGES - 40, NUM_PAGES - 1, 10, 300);
    settle();
    steady = 1'b0;
    repeat (32) @(posedge clk);

    $write("Run covered %0d command beats: alloc %0d, free %0d, add_ref %0d, ",
           cmd_seen[pfra_pkg::CMD_ALLOC] + cmd_seen[pfra_pkg::CMD_FREE] +
           cmd_seen[pfra_pkg::CMD_ADD_REF] + cmd_seen[pfra_pkg::CMD_QUERY] +
           cmd_seen[pfra_pkg::CMD_INIT] + unknown_seen,
           cmd_seen[pfra_pkg::CMD_ALLOC], cmd_seen[pfra_pkg::CMD_FREE],
           cmd_seen[pfra_pkg::CMD_ADD_REF]);
    $display("query %0d, init %0d, unknown %0d",
             cmd_seen[pfra_pkg::CMD_QUERY], cmd_seen[pfra_pkg::CMD_INIT], unknown_seen);
    $write("Statuses checked: ok %0d, out of memory %0d, nonexistent %0d, ",
           status_seen[pfra_pkg::STS_OK], status_seen[pfra_pkg::STS_OOM],
           status_seen[pfra_pkg::STS_NONEXIST]);
    $display("already free %0d, below base %0d, saturated %0d",
             status_seen[pfra_pkg::STS_ALREADY_FREE], status_seen[pfra_pkg::STS_IGNORED_LOW],
             status_seen[pfra_pkg::STS_SATURATED]);
    if (faults == 0) begin
      $display("page_frame_refcount_allocator_unit verification clean");
    end else begin
      $display("page_frame_refcount_allocator_unit verification failed");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run, every command a full
  // table sweep with the sender's longest gaps
  initial begin
    #400_000_000;
    $display("page_frame_refcount_allocator_unit verification failed");
    $finish;
  end

endmodule

/* files.f */
rtl/core/pfra_pkg.sv
rtl/core/pfra_ram.sv
rtl/core/pfra_ctrl.sv
rtl/core/page_frame_refcount_allocator_unit.sv
sim/tb_top.sv
